>>> hw/rtl/vdi_pkg.sv
// Shared types and constants of the vertex deduplication indexer.
package vdi_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W        = 10;
    localparam int COMP_W       = 32;
    localparam int TOL_W        = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

    typedef struct packed {
        logic signed [COMP_W-1:0] pos_x;
        logic signed [COMP_W-1:0] pos_y;
        logic signed [COMP_W-1:0] pos_z;
        logic signed [COMP_W-1:0] norm_x;
        logic signed [COMP_W-1:0] norm_y;
        logic signed [COMP_W-1:0] norm_z;
        logic signed [COMP_W-1:0] tex_u;
        logic signed [COMP_W-1:0] tex_v;
    } corner_t;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             was_new;
        logic             store_full;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
    } scan_tag_t;

endpackage

>>> hw/rtl/vdi_match.sv
// Compare stage: checks one stored vertex against the corner within the tolerance.
module vdi_match (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vdi_pkg::corner_t           stored,
    input  vdi_pkg::corner_t           corner,
    input  logic [vdi_pkg::TOL_W-1:0]  tolerance,
    input  vdi_pkg::scan_tag_t         tag_in,
    output vdi_pkg::scan_tag_t         tag_out,
    output logic                       match
);

    function automatic logic near(
        input logic [vdi_pkg::COMP_W-1:0] a,
        input logic [vdi_pkg::COMP_W-1:0] b,
        input logic [vdi_pkg::TOL_W-1:0]  tol
    );
        logic signed [vdi_pkg::COMP_W:0] diff;
        logic        [vdi_pkg::COMP_W:0] mag;
        diff = $signed({a[vdi_pkg::COMP_W-1], a}) - $signed({b[vdi_pkg::COMP_W-1], b});
        mag  = diff[vdi_pkg::COMP_W] ? (~diff + 1'b1) : diff;
        return mag <= {{(vdi_pkg::COMP_W + 1 - vdi_pkg::TOL_W){1'b0}}, tol};
    endfunction

    vdi_pkg::scan_tag_t tag_reg;
    logic               match_reg;
    logic               match_next;

    assign match_next = near(stored.pos_x,  corner.pos_x,  tolerance)
                      & near(stored.pos_y,  corner.pos_y,  tolerance)
                      & near(stored.pos_z,  corner.pos_z,  tolerance)
                      & near(stored.norm_x, corner.norm_x, tolerance)
                      & near(stored.norm_y, corner.norm_y, tolerance)
                      & near(stored.norm_z, corner.norm_z, tolerance)
                      & near(stored.tex_u,  corner.tex_u,  tolerance)
                      & near(stored.tex_v,  corner.tex_v,  tolerance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            tag_reg   <= tag_in;
            match_reg <= match_next;
        end
    end

    assign tag_out = tag_reg;
    assign match   = match_reg;

endmodule

>>> hw/rtl/vertex_dedup_indexer_top.sv
// Top level of the vertex deduplication indexer: vertex memory, scan sequencer, result register.
// The scan reads stored vertices in index order into a read register and compares each in vdi_match;
// the first match returns its index, else the corner is stored as a new vertex or store_full is set.
// One stored vertex is read a cycle; a new corner is accepted only while idle, one corner at a time.
// Reset clears the vertex count and sets the tolerance to 7; memory contents stay undefined.
// The receiver cannot stall; done strobes for one cycle.
module vertex_dedup_indexer_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  vdi_pkg::corner_t          corner,
    output logic                      done,
    output vdi_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [vdi_pkg::TOL_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                           state_reg, state_next;
    logic [vdi_pkg::TOL_W-1:0]        tol_reg;
    logic [vdi_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [vdi_pkg::CNT_W-1:0]        issue_reg, issue_next;
    vdi_pkg::corner_t                 corner_reg;
    vdi_pkg::corner_t                 mem [vdi_pkg::MAX_VERTICES];
    vdi_pkg::corner_t                 mem_q_reg;
    vdi_pkg::scan_tag_t               s1_reg, s1_next;
    vdi_pkg::scan_tag_t               s2_tag;
    logic                             s2_match;
    logic                             done_reg, done_next;
    vdi_pkg::result_t                 result_reg, result_next;
    logic                             issue;
    logic                             accept;
    logic                             mem_we;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign issue     = (state_reg == S_SCAN) && (issue_reg < count_reg);

    vdi_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .stored    (mem_q_reg),
        .corner    (corner_reg),
        .tolerance (tol_reg),
        .tag_in    (s1_reg),
        .tag_out   (s2_tag),
        .match     (s2_match)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        issue_next  = issue_reg;
        s1_next.valid = 1'b0;
        s1_next.idx   = issue_reg[vdi_pkg::ADDR_W-1:0];
        done_next   = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    issue_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    issue_next    = issue_reg + 1'b1;
                    s1_next.valid = 1'b1;
                end
                priority if (s2_tag.valid && s2_match)
                begin
                    s1_next.valid            = 1'b0;
                    done_next                = 1'b1;
                    result_next.vertex_index = vdi_pkg::IDX_W'(s2_tag.idx);
                    result_next.was_new      = 1'b0;
                    result_next.store_full   = 1'b0;
                    state_next               = S_IDLE;
                end
                else if (!issue && !s1_reg.valid && !s2_tag.valid)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (count_reg == vdi_pkg::CNT_W'(vdi_pkg::MAX_VERTICES))
                    begin
                        result_next.vertex_index = '0;
                        result_next.was_new      = 1'b0;
                        result_next.store_full   = 1'b1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        result_next.vertex_index =
                            vdi_pkg::IDX_W'(count_reg[vdi_pkg::ADDR_W-1:0]);
                        result_next.was_new      = 1'b1;
                        result_next.store_full   = 1'b0;
                    end
                end
                else
                begin
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            tol_reg      <= vdi_pkg::TOL_RESET;
            s1_reg       <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            s1_reg       <= s1_next;
            done_reg     <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg  <= issue_next;
        result_reg <= result_next;
        if (accept)
        begin
            corner_reg <= corner;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[vdi_pkg::ADDR_W-1:0]] <= corner_reg;
        end
        mem_q_reg <= mem[issue_reg[vdi_pkg::ADDR_W-1:0]];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
